// File: hdl/sarc_pkg.sv
// Shared types and constants for the set-associative read cache.
// Used by sarc_ctrl, sarc_dpath and set_assoc_read_cache; no dependencies.
package sarc_pkg;

  localparam int ADDR_W     = 32;
  localparam int LINE_BYTES = 8;
  localparam int OFFSET_W   = 3;
  localparam int SET_COUNT  = 1024;
  localparam int SET_W      = 10;
  localparam int WAY_COUNT  = 8;
  localparam int WAY_W      = 3;
  localparam int TAG_W      = ADDR_W - SET_W - OFFSET_W;
  localparam int LINE_W     = 8 * LINE_BYTES;
  localparam int LADDR_W    = ADDR_W - OFFSET_W;
  localparam int LEN_W      = 3;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SEED_W     = 16;

  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

  localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FILL = 2'd2;

  // read address source for the tag and line memories
  localparam logic [1:0] RD_INPUT  = 2'd0;
  localparam logic [1:0] RD_FIRST  = 2'd1;
  localparam logic [1:0] RD_SECOND = 2'd2;

  typedef struct packed {
    logic             accept;     // latch the incoming item
    logic [1:0]       rd_sel;
    logic             clear_we;   // invalidate all ways of clear_set
    logic [SET_W-1:0] clear_set;
    logic             fill_we;    // install the fill line
    logic             line1_load; // keep first line while the second is looked up
    logic             phase2;     // lookup in flight is the second line
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_fill;
    logic hit;
    logic crossing;
  } dp_status_t;

endpackage

// File: hdl/set_assoc_read_cache.sv
// Read-only 8-way set-associative cache, 1024 sets of 8-byte lines, random
// (LFSR) replacement. Depends on sarc_pkg, sarc_ctrl, sarc_dpath.
//
// Input channel (in_valid/in_stall) carries one item: a read of 1 to 4 bytes
// (command 0) or a line fill (command 1). Output channel (out_valid/out_stall)
// returns exactly one item per input: hit with data, miss with the line
// address to fetch, or fill done. After a miss the caller fills the line and
// repeats the read.
// A result is registered after a lookup of the per-way tag and line memories;
// a read that crosses a line boundary takes a second lookup first. No new
// item is taken until the result of the last one has been loaded into the
// output register; the second lookup reuses the single read port of each way.
// Reset: the sequencer first sweeps all 1024 sets clearing valid bits, one
// set per cycle; in_stall is high throughout the sweep. The LFSR loads 44257.
// cfg_we loads the LFSR seed (zero is taken as one); write only while idle.
// A held result stays in the output register while out_stall is high; the
// next item is still accepted, but its result waits until the held one goes.
module set_assoc_read_cache (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sarc_pkg::SEED_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic [sarc_pkg::ADDR_W-1:0]     address,
  input  logic [sarc_pkg::LEN_W-1:0]      access_length,
  input  logic [sarc_pkg::LINE_W-1:0]     fill_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sarc_pkg::STATUS_W-1:0]   status,
  output logic [sarc_pkg::DATA_W-1:0]     read_data,
  output logic [sarc_pkg::ADDR_W-1:0]     fetch_address
);
  import sarc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  sarc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status_in (dp_status),
    .cmd       (cmd)
  );

  sarc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status_out    (dp_status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .command       (command),
    .address       (address),
    .access_length (access_length),
    .fill_data     (fill_data),
    .status        (status),
    .read_data     (read_data),
    .fetch_address (fetch_address)
  );

endmodule

// File: hdl/sarc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sarc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sarc_ctrl.sv
// Sequencer for the cache: clearing pass, item accept, one or two lookups,
// result hand-off. Depends on sarc_pkg.
module sarc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  sarc_pkg::dp_status_t  status_in,
  output sarc_pkg::ctrl_cmd_t   cmd
);
  import sarc_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK1 = 2'd2;
  localparam logic [1:0] ST_LOOK2 = 2'd3;

  logic [1:0]       state, state_next;
  logic [SET_W-1:0] clear_cnt;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = RD_INPUT;
    cmd.clear_set  = clear_cnt;
    cmd.phase2     = (state == ST_LOOK2);
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (clear_cnt == SET_W'(SET_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_LOOK1;
        end
      end
      ST_LOOK1: begin
        cmd.rd_sel = RD_FIRST;
        priority if (!status_in.is_fill && status_in.hit && status_in.crossing) begin
          cmd.line1_load = 1'b1;
          cmd.rd_sel     = RD_SECOND;
          state_next     = ST_LOOK2;
        end else if (out_free) begin
          cmd.fill_we  = status_in.is_fill;
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_LOOK1;
        end
      end
      ST_LOOK2: begin
        cmd.rd_sel = RD_SECOND;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_cnt <= clear_cnt + SET_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/sarc_dpath.sv
// Cache datapath: item registers, per-way tag and line memories, hit logic,
// byte extraction, victim LFSR and result registers. Depends on sarc_pkg, sarc_ram.
module sarc_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  sarc_pkg::ctrl_cmd_t             cmd,
  output sarc_pkg::dp_status_t            status_out,
  input  logic                            cfg_we,
  input  logic [sarc_pkg::SEED_W-1:0]     cfg_wdata,
  input  logic                            command,
  input  logic [sarc_pkg::ADDR_W-1:0]     address,
  input  logic [sarc_pkg::LEN_W-1:0]      access_length,
  input  logic [sarc_pkg::LINE_W-1:0]     fill_data,
  output logic [sarc_pkg::STATUS_W-1:0]   status,
  output logic [sarc_pkg::DATA_W-1:0]     read_data,
  output logic [sarc_pkg::ADDR_W-1:0]     fetch_address
);
  import sarc_pkg::*;

  logic              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q;
  logic [LINE_W-1:0] fill_q;
  logic [LINE_W-1:0] line1;
  logic [SEED_W-1:0] lfsr;

  logic [LADDR_W-1:0]   line_a, line_b;
  logic [TAG_W-1:0]     tag_a, tag_b, tag_cmp;
  logic [SET_W-1:0]     raddr, waddr;
  logic [LEN_W-1:0]     len_eff;
  logic [OFFSET_W-1:0]  offset;

  logic [TAG_W:0]       tag_rd   [WAY_COUNT];
  logic [LINE_W-1:0]    line_rd  [WAY_COUNT];
  logic [WAY_COUNT-1:0] way_hit;
  logic [WAY_COUNT-1:0] way_we;
  logic [LINE_W-1:0]    hit_line;
  logic [WAY_W-1:0]     hit_way, fill_way;
  logic                 any_hit;
  logic [TAG_W:0]       tag_wdata;
  logic                 tag_we;

  logic [2*LINE_W-1:0]  pair;
  logic [2*LINE_W-1:0]  shifted;
  logic [DATA_W-1:0]    bytes_sel;

  assign line_a  = addr_q[ADDR_W-1:OFFSET_W];
  assign line_b  = line_a + LADDR_W'(1);   // wraps at the top of memory
  assign tag_a   = line_a[LADDR_W-1:SET_W];
  assign tag_b   = line_b[LADDR_W-1:SET_W];
  assign tag_cmp = cmd.phase2 ? tag_b : tag_a;
  assign offset  = addr_q[OFFSET_W-1:0];
  assign len_eff = (len_q > LEN_W'(4)) ? LEN_W'(4) : len_q;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_INPUT:  raddr = address[OFFSET_W+SET_W-1:OFFSET_W];
      RD_FIRST:  raddr = line_a[SET_W-1:0];
      RD_SECOND: raddr = line_b[SET_W-1:0];
      default:   raddr = line_a[SET_W-1:0];
    endcase
  end

  // hit detection over the ways
  always_comb begin
    hit_line = '0;
    hit_way  = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      way_hit[w] = tag_rd[w][TAG_W] && (tag_rd[w][TAG_W-1:0] == tag_cmp);
      if (way_hit[w]) begin
        hit_line = hit_line | line_rd[w];
        hit_way  = hit_way | WAY_W'(w);
      end
    end
  end
  assign any_hit = |way_hit;

  // a fill of a present line rewrites it in place
  assign fill_way  = any_hit ? hit_way : lfsr[WAY_W-1:0];
  assign waddr     = cmd.clear_we ? cmd.clear_set : line_a[SET_W-1:0];
  assign tag_we    = cmd.clear_we || cmd.fill_we;
  assign tag_wdata = cmd.clear_we ? '0 : {1'b1, tag_a};

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      way_we[w] = cmd.clear_we || (cmd.fill_we && (fill_way == WAY_W'(w)));
    end
  end

  for (genvar g = 0; g < WAY_COUNT; g++) begin : g_way
    sarc_ram #(.WIDTH(TAG_W + 1), .DEPTH(SET_COUNT)) u_tag (
      .clk   (clk),
      .we    (way_we[g] && tag_we),
      .waddr (waddr),
      .wdata (tag_wdata),
      .raddr (raddr),
      .rdata (tag_rd[g])
    );
    sarc_ram #(.WIDTH(LINE_W), .DEPTH(SET_COUNT)) u_line (
      .clk   (clk),
      .we    (way_we[g] && cmd.fill_we),
      .waddr (waddr),
      .wdata (fill_q),
      .raddr (raddr),
      .rdata (line_rd[g])
    );
  end

  assign status_out.is_fill  = cmd_q;
  assign status_out.hit      = any_hit;
  assign status_out.crossing = ({1'b0, offset} + {1'b0, len_eff}) > (OFFSET_W + 1)'(LINE_BYTES);

  // byte extraction across one or two lines
  assign pair    = cmd.phase2 ? {hit_line, line1} : {{LINE_W{1'b0}}, hit_line};
  assign shifted = pair >> {offset, 3'b000};
  always_comb begin
    for (int i = 0; i < DATA_W / 8; i++) begin
      bytes_sel[8*i +: 8] = (LEN_W'(i) < len_eff) ? shifted[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_RESET;
    end else if (cfg_we) begin
      lfsr <= (cfg_wdata == '0) ? SEED_W'(1) : cfg_wdata;
    end else if (cmd.fill_we && !any_hit) begin
      lfsr <= {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q  <= command;
      addr_q <= address;
      len_q  <= access_length;
      fill_q <= fill_data;
    end
    if (cmd.line1_load) begin
      line1 <= hit_line;
    end
    if (cmd.out_load) begin
      priority if (cmd_q) begin
        status        <= STATUS_FILL;
        read_data     <= '0;
        fetch_address <= '0;
      end else if (!any_hit) begin
        status        <= STATUS_MISS;
        read_data     <= '0;
        fetch_address <= cmd.phase2 ? {line_b, {OFFSET_W{1'b0}}}
                                    : {line_a, {OFFSET_W{1'b0}}};
      end else begin
        status        <= STATUS_HIT;
        read_data     <= bytes_sel;
        fetch_address <= '0;
      end
    end
  end

endmodule
